// File: rtl/core/sfq_pkg.sv
// Package for the searchable FIFO queue: ring depth, derived widths,
// command and status codes, controller states and the ring-advance helper.
// Depends on nothing; imported by searchable_fifo_queue.
`default_nettype none

package sfq_pkg;

  localparam int unsigned Depth   = 16;
  localparam int unsigned DataW   = 32;
  localparam int unsigned IdxW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW    = $clog2(Depth + 1);
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 4;
  localparam int unsigned OccW    = 5;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [CmdW-1:0] {
    CmdEnq  = 2'd0,
    CmdDeq  = 2'd1,
    CmdSrch = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StatDone  = 2'd0,
    StatEmpty = 2'd1,
    StatFull  = 2'd2
  } status_e;

  typedef enum logic {
    StIdle,
    StSearch
  } state_e;

  // Advance a ring index, wrapping at the last entry.
  function automatic idx_t ring_next(input idx_t idx);
    ring_next = (idx == idx_t'(Depth - 1)) ? '0 : idx + idx_t'(1);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/searchable_fifo_queue.sv
// Top level of the searchable FIFO queue: head/tail/count registers, the
// command sequencer and the search walk. Depends on sfq_pkg and sfq_ram.
// Usage: a transfer in happens when start_i is high and busy_o is low. Every
// command returns exactly one result, shown for one cycle with done_o high in
// the cycle after the command completes; the receiver cannot stall, so
// capture it then. Enqueue, dequeue and the unused command complete in the
// cycle they are taken and busy_o stays low, so one such command can follow
// every cycle. A search on an empty queue is equally quick. Otherwise a
// search walks the held entries oldest first through the single read port of
// the entry RAM, one entry per cycle: it holds busy_o until the first match
// or, with no match, until all held entries (at most 16) have been read, and
// its result shows in the cycle busy_o falls. There is no clearing pass after
// reset: only held entries are ever compared.
`default_nettype none

module searchable_fifo_queue
  import sfq_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic        [CmdW-1:0]    cmd_i,
  input  wire logic signed [DataW-1:0]   value_i,
  output logic                           done_o,
  output logic             [StatusW-1:0] status_o,
  output logic                           found_o,
  output logic             [PosW-1:0]    position_o,
  output logic             [OccW-1:0]    occupancy_o
);

  // Control state.
  state_e state_q, state_d;
  idx_t   head_q, head_d;
  idx_t   tail_q, tail_d;
  cnt_t   count_q, count_d;
  idx_t   rd_idx_q, rd_idx_d;   // ring index of the next entry to read
  idx_t   k_q, k_d;             // position of the entry now on rdata
  logic   done_q, done_d;

  // Payload: search key and result registers.
  logic [DataW-1:0]   key_q, key_d;
  logic [StatusW-1:0] status_q, status_d;
  logic               found_q, found_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [OccW-1:0]    occ_q, occ_d;

  logic             accept;
  logic             ram_we;
  idx_t             ram_raddr;
  logic [DataW-1:0] ram_rdata;

  assign accept = start_i && (state_q == StIdle);

  // Read the head at acceptance, then the walk pointer during a search.
  assign ram_raddr = (state_q == StIdle) ? head_q : rd_idx_q;

  sfq_ram #(
    .Depth (Depth),
    .Width (DataW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    rd_idx_d = rd_idx_q;
    k_d      = k_q;
    done_d   = 1'b0;
    key_d    = key_q;
    status_d = status_q;
    found_d  = found_q;
    pos_d    = pos_q;
    occ_d    = occ_q;
    ram_we   = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          // Default result: done, nothing found, occupancy as held.
          status_d = StatDone;
          found_d  = 1'b0;
          pos_d    = '0;
          occ_d    = OccW'(count_q);
          done_d   = 1'b1;
          unique case (cmd_i)
            CmdEnq: begin
              if (count_q >= cnt_t'(Depth)) begin
                status_d = StatFull;  // drop the value
              end else begin
                ram_we  = 1'b1;
                tail_d  = ring_next(tail_q);
                count_d = count_q + cnt_t'(1);
                occ_d   = OccW'(count_q + cnt_t'(1));
              end
            end
            CmdDeq: begin
              if (count_q == '0) begin
                status_d = StatEmpty;
              end else begin
                head_d  = ring_next(head_q);
                count_d = count_q - cnt_t'(1);
                occ_d   = OccW'(count_q - cnt_t'(1));
              end
            end
            CmdSrch: begin
              if (count_q != '0) begin
                // Head read is issued this cycle; hold the result until the walk ends.
                done_d   = 1'b0;
                key_d    = value_i;
                rd_idx_d = ring_next(head_q);
                k_d      = '0;
                state_d  = StSearch;
              end
            end
            default: begin
              // Unused command: report occupancy, change nothing.
            end
          endcase
        end
      end
      StSearch: begin
        if (ram_rdata == key_q) begin
          found_d = 1'b1;
          pos_d   = PosW'(k_q);
          done_d  = 1'b1;
          state_d = StIdle;
        end else if (cnt_t'(k_q) + cnt_t'(1) == count_q) begin
          done_d  = 1'b1;
          state_d = StIdle;
        end else begin
          // Advance the walk: the read of rd_idx_q goes out this cycle.
          rd_idx_d = ring_next(rd_idx_q);
          k_d      = k_q + idx_t'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      rd_idx_q <= '0;
      k_q      <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      k_q      <= k_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    status_q <= status_d;
    found_q  <= found_d;
    pos_q    <= pos_d;
    occ_q    <= occ_d;
  end

  assign busy_o      = (state_q != StIdle);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign position_o  = pos_q;
  assign occupancy_o = occ_q;

  // A search walk only runs over held entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSearch) |-> (cnt_t'(k_q) < count_q))
    else $error("search position beyond held entries");

  // The count never exceeds the ring depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(Depth))
    else $error("entry count above depth");

  // A search on a non-empty queue enters the walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == CmdSrch) && (count_q != '0)) |=> (busy_o && !done_o))
    else $error("search did not start walk");

  // A found result is always a completed search with status done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (status_o == StatDone))
    else $error("found flag with non-done status");

  // The entry count is unchanged during a search walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSearch) |=> $stable(count_q))
    else $error("count changed during search");

endmodule

`default_nettype wire

// File: rtl/core/sfq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used by searchable_fifo_queue as the entry store.
`default_nettype none

module sfq_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: verif/searchable_fifo_queue_tb.sv
// Self-checking testbench for searchable_fifo_queue: directed table, then biased
// random command streams under three sender idle profiles, checked in order.
// Depends on sfq_pkg and the searchable_fifo_queue RTL.
`timescale 1ns / 1ps

module searchable_fifo_queue_tb
  import sfq_pkg::*;
;

  // Command code the block treats as a no-op; the package leaves it unnamed.
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  // Cycles without any transfer, in or out, before the run is declared hung.
  // The slowest legal gap is a full search walk plus a sender pause.
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned PrintLimit    = 40;
  localparam int unsigned PhaseItems    = 440;

  typedef struct packed {
    status_e             status;
    logic                found;
    logic [PosW-1:0]     position;
    logic [OccW-1:0]     occupancy;
  } queue_result_t;

  // One row of the directed table. A row with reps > 1 repeats its command,
  // advancing the word by one each time. A typed row carries its result as
  // written here instead of the one the predictor works out.
  typedef struct {
    logic [CmdW-1:0]  cmd;
    logic [DataW-1:0] word;
    int unsigned      reps;
    bit               typed;
    queue_result_t    want;
  } stim_row_t;

  localparam queue_result_t NoTyped = '0;
  localparam int unsigned NumRows = 20;

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 start_i = 1'b0;
  logic [CmdW-1:0]      cmd_i   = CmdEnq;
  logic [DataW-1:0]     value_i = '0;
  logic                 busy_o;
  logic                 done_o;
  logic [StatusW-1:0]   status_o;
  logic                 found_o;
  logic [PosW-1:0]      position_o;
  logic [OccW-1:0]      occupancy_o;

  // Predictor state: the words held, oldest first.
  logic [DataW-1:0]     held_words[$];
  // Results owed by the block, oldest first.
  queue_result_t        pending_results[$];
  queue_result_t        oldest_want;
  int unsigned          mismatch_count = 0;
  int unsigned          quiet_cycles   = 0;
  logic [DataW-1:0]     word_pool[8];

  stim_row_t stim_table [NumRows] = '{
    // empty queue after reset: dequeue is ignored, search finds nothing
    '{CmdDeq,    32'h0000_0000, 1,  1'b1, '{StatEmpty, 1'b0, 4'd0,  5'd0}},
    '{CmdSrch,   32'h0000_0000, 1,  1'b1, '{StatDone,  1'b0, 4'd0,  5'd0}},
    '{CmdUnused, 32'hFFFF_FFFF, 1,  1'b1, '{StatDone,  1'b0, 4'd0,  5'd0}},
    // value extremes
    '{CmdEnq,    32'h8000_0000, 1,  1'b1, '{StatDone,  1'b0, 4'd0,  5'd1}},
    '{CmdEnq,    32'h7FFF_FFFF, 1,  1'b1, '{StatDone,  1'b0, 4'd0,  5'd2}},
    '{CmdSrch,   32'h7FFF_FFFF, 1,  1'b1, '{StatDone,  1'b1, 4'd1,  5'd2}},
    '{CmdSrch,   32'h8000_0000, 1,  1'b1, '{StatDone,  1'b1, 4'd0,  5'd2}},
    '{CmdSrch,   32'h0000_0000, 1,  1'b0, NoTyped},
    '{CmdUnused, 32'h0000_0000, 1,  1'b1, '{StatDone,  1'b0, 4'd0,  5'd2}},
    // duplicate word: after the first copy leaves, the second one matches
    '{CmdEnq,    32'h8000_0000, 1,  1'b0, NoTyped},
    '{CmdDeq,    32'h0000_0000, 1,  1'b0, NoTyped},
    '{CmdSrch,   32'h8000_0000, 1,  1'b0, NoTyped},
    // fill to the brim, then push once more
    '{CmdEnq,    32'h5555_5550, 14, 1'b0, NoTyped},
    '{CmdEnq,    32'h0000_1234, 1,  1'b1, '{StatFull,  1'b0, 4'd0,  5'd16}},
    '{CmdSrch,   32'h5555_555D, 1,  1'b0, NoTyped},
    '{CmdSrch,   32'hAAAA_AAAA, 1,  1'b0, NoTyped},
    // drain completely, then once more on empty
    '{CmdDeq,    32'h0000_0000, 16, 1'b0, NoTyped},
    '{CmdDeq,    32'hFFFF_FFFF, 1,  1'b1, '{StatEmpty, 1'b0, 4'd0,  5'd0}},
    '{CmdEnq,    32'hFFFF_FFFF, 1,  1'b0, NoTyped},
    '{CmdSrch,   32'hFFFF_FFFF, 1,  1'b0, NoTyped}
  };

  searchable_fifo_queue u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .found_o     (found_o),
    .position_o  (position_o),
    .occupancy_o (occupancy_o)
  );

  always #1 clk_i = ~clk_i;

  // Apply one command to the predictor state and return the result it owes.
  function automatic queue_result_t apply_command(input logic [CmdW-1:0]  cmd,
                                                  input logic [DataW-1:0] word);
    queue_result_t res;
    res = NoTyped;
    res.status = StatDone;
    case (cmd)
      CmdEnq: begin
        if (held_words.size() >= Depth) res.status = StatFull;
        else held_words.push_back(word);
      end
      CmdDeq: begin
        if (held_words.size() == 0) res.status = StatEmpty;
        else void'(held_words.pop_front());
      end
      CmdSrch: begin
        // first match from the oldest entry wins
        for (int k = 0; k < held_words.size(); k++) begin
          if (held_words[k] == word) begin
            res.found    = 1'b1;
            res.position = PosW'(k);
            break;
          end
        end
      end
      default: ;
    endcase
    res.occupancy = OccW'(held_words.size());
    return res;
  endfunction

  function automatic logic [DataW-1:0] pick_extreme();
    case ($urandom_range(3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Present one command and hold it until the block takes it. At the edge of
  // the transfer, predict its result and queue it; then idle at random.
  task automatic issue_command(input logic [CmdW-1:0]  cmd,
                               input logic [DataW-1:0] word,
                               input bit               typed,
                               input queue_result_t    typed_want,
                               input int unsigned      idle_pct);
    queue_result_t predicted;
    start_i <= 1'b1;
    cmd_i   <= cmd;
    value_i <= word;
    // busy_o read here is its value before this edge's updates, which is
    // exactly what decides the transfer
    do @(posedge clk_i); while (busy_o);
    predicted = apply_command(cmd, word);
    pending_results.push_back(typed ? typed_want : predicted);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Drop start and hold off until every owed result has come back. Always
  // wait on a clock edge first so start never falls and rises in one step.
  task automatic await_drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Biased random commands. Every so often pick a new mood (fill, drain or
  // balanced) and a fresh word pool, so the ring runs full and empty often
  // and searches hit held words at every position.
  task automatic run_random(input int unsigned n_items, input int unsigned idle_pct);
    int unsigned      roll;
    int unsigned      mood;
    int unsigned      enq_pct;
    int unsigned      deq_pct;
    logic [CmdW-1:0]  cmd;
    logic [DataW-1:0] word;
    mood = 2;
    for (int unsigned n = 0; n < n_items; n++) begin
      if (n % 40 == 0) begin
        mood = $urandom_range(2);
        foreach (word_pool[i]) word_pool[i] = $urandom();
      end
      enq_pct = (mood == 0) ? 55 : (mood == 1) ? 20 : 35;
      deq_pct = (mood == 0) ? 15 : (mood == 1) ? 45 : 30;
      roll = $urandom_range(99);
      if (roll < enq_pct) cmd = CmdEnq;
      else if (roll < enq_pct + deq_pct) cmd = CmdDeq;
      else if (roll < enq_pct + deq_pct + 3) cmd = CmdUnused;
      else cmd = CmdSrch;

      roll = $urandom_range(99);
      if (cmd == CmdSrch && roll < 40 && held_words.size() != 0)
        word = held_words[$urandom_range(held_words.size() - 1)];
      else if (roll < 75) word = word_pool[$urandom_range(7)];
      else if (roll < 85) word = pick_extreme();
      else word = $urandom();
      issue_command(cmd, word, 1'b0, NoTyped, idle_pct);
    end
  endtask

  task automatic report_field(input string name, input logic [DataW-1:0] want,
                              input logic [DataW-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= PrintLimit)
        $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, want, got);
    end
  endtask

  // Result checker. The block cannot be held off, so capture on every strobe
  // and compare against the oldest owed result.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= PrintLimit)
          $display("%0t: unexpected result, expected none actual status %0h occupancy %0h",
                   $realtime, status_o, occupancy_o);
      end else begin
        oldest_want = pending_results.pop_front();
        report_field("status",    DataW'(oldest_want.status),    DataW'(status_o));
        report_field("found",     DataW'(oldest_want.found),     DataW'(found_o));
        report_field("position",  DataW'(oldest_want.position),  DataW'(position_o));
        report_field("occupancy", DataW'(oldest_want.occupancy), DataW'(occupancy_o));
      end
    end
  end

  // Watchdog: count edges with no transfer on either side.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned idle_profile[3];
    idle_profile = '{11, 74, 0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; expand repeated rows with a stepping word.
    foreach (stim_table[r]) begin
      for (int unsigned k = 0; k < stim_table[r].reps; k++)
        issue_command(stim_table[r].cmd, stim_table[r].word + DataW'(k),
                      stim_table[r].typed, stim_table[r].want, 30);
    end
    await_drain();

    // Random phases: light sender idling, heavy idling, then back to back.
    // Drain between phases so the sender also waits on a quiet block.
    foreach (idle_profile[p]) begin
      run_random(PhaseItems, idle_profile[p]);
      await_drain();
    end

    // Let any stray strobe show up before the verdict.
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/sfq_pkg.sv
rtl/core/sfq_ram.sv
rtl/core/searchable_fifo_queue.sv
verif/searchable_fifo_queue_tb.sv
